// ----- rtl/aes_encrypt_round_unit_defines.svh -----
// Assertion macros for the AES round unit.
`ifndef AES_ENCRYPT_ROUND_UNIT_DEFINES_SVH
`define AES_ENCRYPT_ROUND_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// ante |-> cons, sampled on clk, off while rst is high
`define AESR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes round unit: assertion failed");

// ante |=> cons, sampled on clk, off while rst is high
`define AESR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes round unit: assertion failed");

// ante |=> cons, also checked across reset
`define AESR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("aes round unit: reset assertion failed");

`else

`define AESR_ASSERT_IMP(lbl, ante, cons)
`define AESR_ASSERT_NXT(lbl, ante, cons)
`define AESR_ASSERT_RST(lbl, ante, cons)

`endif

`endif

// ----- rtl/aesr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aesr_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned BLOCK_W = 2 * HALF_W;
  localparam int unsigned NBYTES  = BLOCK_W / 8;

  localparam logic [8:0] GF_POLY = 9'h11B;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_KEY = 2'd0,
    MODE_FULL    = 2'd1,
    MODE_FINAL   = 2'd2
  } mode_t;

  typedef logic [7:0] byte_t;

  // entry [row + 4*k]: coefficient for output row, input row k
  localparam logic [1:0] MIX_COEF [16] = '{
    2'd2, 2'd1, 2'd1, 2'd3,
    2'd3, 2'd2, 2'd1, 2'd1,
    2'd1, 2'd3, 2'd2, 2'd1,
    2'd1, 2'd1, 2'd3, 2'd2
  };

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t sub_byte(input byte_t b);
    return SBOX[b];
  endfunction

  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY[7:0] : 8'h00);
  endfunction

  // product by a MixColumns coefficient (1, 2 or 3)
  function automatic byte_t gf_mul_coef(input byte_t b, input logic [1:0] coef);
    byte_t p;
    p = 8'h00;
    case (coef)
      2'd1:    p = b;
      2'd2:    p = xtime(b);
      2'd3:    p = xtime(b) ^ b;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/aes_encrypt_round_unit.sv -----
// One AES-128 encryption round per word: add round key only, a full round
// (SubBytes, ShiftRows, MixColumns, AddRoundKey) or a final round without
// MixColumns, as mode selects; mode 3 acts as add round key. Bytes are in the
// standard column-major order, byte 0 in the top bits of state_hi. A word is
// taken in every cycle unless the input stalls; it passes through one input
// register and one result register, which presents the result, with the
// S-box lookup, MixColumns and key add between them. The input stalls
// only while both registers hold a word and the output is stalled. There
// is no internal state beyond the pipeline.
`timescale 1ns / 1ps
`default_nettype none

`include "aes_encrypt_round_unit_defines.svh"

module aes_encrypt_round_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aesr_pkg::MODE_W-1:0]   mode,
  input  logic [aesr_pkg::HALF_W-1:0]   state_hi,
  input  logic [aesr_pkg::HALF_W-1:0]   state_lo,
  input  logic [aesr_pkg::HALF_W-1:0]   key_hi,
  input  logic [aesr_pkg::HALF_W-1:0]   key_lo,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aesr_pkg::HALF_W-1:0]   result_hi,
  output logic [aesr_pkg::HALF_W-1:0]   result_lo
);

  import aesr_pkg::*;

  logic                s1_valid;
  logic [MODE_W-1:0]   mode_q;
  logic [BLOCK_W-1:0]  state_q;
  logic [BLOCK_W-1:0]  key_q;

  logic                adv_out;
  logic                adv_in;

  byte_t               st_b  [NBYTES];
  byte_t               key_b [NBYTES];
  byte_t               sub_b [NBYTES];
  byte_t               sh_b  [NBYTES];
  byte_t               mix_b [NBYTES];
  byte_t               pre_b [NBYTES];
  logic [BLOCK_W-1:0]  result_next;

  assign adv_out  = !out_valid || !out_stall;
  assign adv_in   = !s1_valid || adv_out;
  assign in_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        s1_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      mode_q  <= mode;
      state_q <= {state_hi, state_lo};
      key_q   <= {key_hi, key_lo};
    end
    if (adv_out && s1_valid) begin
      result_hi <= result_next[BLOCK_W-1:HALF_W];
      result_lo <= result_next[HALF_W-1:0];
    end
  end

  always_comb begin
    byte_t acc;
    acc = 8'h00;
    for (int i = 0; i < NBYTES; i++) begin
      st_b[i]  = state_q[BLOCK_W-1-8*i -: 8];
      key_b[i] = key_q[BLOCK_W-1-8*i -: 8];
      sub_b[i] = sub_byte(st_b[i]);
    end
    // row r rotates left by r columns
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh_b[r + 4*c] = sub_b[r + 4*((c + r) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gf_mul_coef(sh_b[4*c + k], MIX_COEF[r + 4*k]);
        end
        mix_b[r + 4*c] = acc;
      end
    end
    for (int i = 0; i < NBYTES; i++) begin
      case (mode_t'(mode_q))
        MODE_ADD_KEY: pre_b[i] = st_b[i];
        MODE_FULL:    pre_b[i] = mix_b[i];
        MODE_FINAL:   pre_b[i] = sh_b[i];
        default:      pre_b[i] = st_b[i];
      endcase
      result_next[BLOCK_W-1-8*i -: 8] = pre_b[i] ^ key_b[i];
    end
  end

  `AESR_ASSERT_RST(a_reset_empty, rst, !s1_valid && !out_valid)
  `AESR_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid && out_valid && out_stall)
  `AESR_ASSERT_NXT(a_accept_loads, in_valid && !in_stall, s1_valid)
  `AESR_ASSERT_NXT(a_hold_input, s1_valid && out_valid && out_stall, s1_valid && $stable(state_q))
  `AESR_ASSERT_NXT(a_add_key_hi, s1_valid && adv_out && mode_q == MODE_ADD_KEY,
    result_hi == $past(state_q[BLOCK_W-1:HALF_W] ^ key_q[BLOCK_W-1:HALF_W]))

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import aesr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [8:0] REDUCE_POLY = 9'h11B;
  localparam byte_t AFFINE_C = 8'h63;
  localparam int N_DIRECTED = 17;
  localparam int N_RANDOM = 933;
  localparam int PRESSURE_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [MODE_W-1:0] m;
    logic [127:0] st;
    logic [127:0] rk;
    logic known;
    logic [127:0] want;
  } round_vec_t;

  localparam logic [127:0] ONES = {128{1'b1}};

  localparam round_vec_t DIRECTED [N_DIRECTED] = '{
    {MODE_ADD_KEY, 128'h0, 128'h0, 1'b1, 128'h0},
    {MODE_ADD_KEY, ONES, 128'h0, 1'b1, ONES},
    {MODE_ADD_KEY, 128'h0, ONES, 1'b1, ONES},
    {MODE_ADD_KEY, 128'h0123456789abcdef0011223344556677,
     128'hffeeddccbbaa99887766554433221100, 1'b0, 128'h0},
    {MODE_SPARE, {16{8'h0f}}, {16{8'h3c}}, 1'b1, {16{8'h33}}},
    {MODE_SPARE, ONES, ONES, 1'b1, 128'h0},
    {MODE_FINAL, 128'h0, 128'h0, 1'b1, {16{8'h63}}},
    {MODE_FINAL, 128'h0, ONES, 1'b1, {16{8'h9c}}},
    {MODE_FULL, 128'h0, 128'h0, 1'b1, {16{8'h63}}},
    {MODE_FULL, ONES, 128'h0, 1'b1, {16{8'h16}}},
    {MODE_FULL, 128'h193de3bea0f4e22b9ac68d2ae9f84808,
     128'ha0fafe1788542cb123a339392a6c7605, 1'b0, 128'h0},
    {MODE_FINAL, 128'heb598b1b402ea1c3f23813421e84e7d2,
     128'hd014f9a8c9ee2589e13f0cc8b6630ca6, 1'b0, 128'h0},
    {MODE_FULL, {1'b1, 127'h0}, 128'h0, 1'b0, 128'h0},
    {MODE_FINAL, 128'h1, {1'b1, 127'h0}, 1'b0, 128'h0},
    {MODE_FULL, ONES, ONES, 1'b0, 128'h0},
    {MODE_FULL, 128'h00112233445566778899aabbccddeeff,
     128'h000102030405060708090a0b0c0d0e0f, 1'b0, 128'h0},
    {MODE_ADD_KEY, ONES, ONES, 1'b1, 128'h0}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [HALF_W-1:0] state_hi = '0;
  logic [HALF_W-1:0] state_lo = '0;
  logic [HALF_W-1:0] key_hi = '0;
  logic [HALF_W-1:0] key_lo = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HALF_W-1:0] result_hi;
  logic [HALF_W-1:0] result_lo;

  byte_t sbox_lut [256];
  logic [127:0] expected_rounds [$];
  int error_count = 0;
  int results_seen = 0;
  bit no_gaps = 1'b0;

  aes_encrypt_round_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .state_hi  (state_hi),
    .state_lo  (state_lo),
    .key_hi    (key_hi),
    .key_lo    (key_lo),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_hi (result_hi),
    .result_lo (result_lo)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    logic [8:0] x;
    byte_t acc;
    int i;
    x = {1'b0, a};
    acc = 8'h00;
    for (i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x ^= REDUCE_POLY;
    end
    return acc;
  endfunction

  // S-box from the field inverse and the affine map
  function automatic void build_sbox();
    byte_t inv, rot, s;
    int x, y, j;
    for (x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (y = 1; y < 256; y++)
        if (x != 0 && gf_mul(byte_t'(x), byte_t'(y)) == 8'h01) inv = byte_t'(y);
      rot = inv;
      s = inv;
      for (j = 0; j < 4; j++) begin
        rot = {rot[6:0], rot[7]};
        s ^= rot;
      end
      sbox_lut[x] = s ^ AFFINE_C;
    end
  endfunction

  function automatic logic [127:0] aes_round(input logic [MODE_W-1:0] m,
                                             input logic [127:0] st,
                                             input logic [127:0] rk);
    byte_t b [16];
    byte_t s [16];
    logic [127:0] res;
    int i, c, r;
    for (i = 0; i < 16; i++) b[i] = st[127-8*i -: 8];
    if (m == MODE_FULL || m == MODE_FINAL) begin
      for (i = 0; i < 16; i++) s[i] = sbox_lut[b[i]];
      for (c = 0; c < 4; c++)
        for (r = 0; r < 4; r++) b[r+4*c] = s[r+4*((c+r)%4)];
      if (m == MODE_FULL) begin
        for (i = 0; i < 16; i++) s[i] = b[i];
        for (c = 0; c < 4; c++)
          for (r = 0; r < 4; r++)
            b[r+4*c] = gf_mul(s[4*c+r], 8'd2) ^ gf_mul(s[4*c+(r+1)%4], 8'd3)
                       ^ s[4*c+(r+2)%4] ^ s[4*c+(r+3)%4];
      end
    end
    for (i = 0; i < 16; i++) res[127-8*i -: 8] = b[i] ^ rk[127-8*i -: 8];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [127:0] st,
                           input logic [127:0] rk, input logic known,
                           input logic [127:0] want);
    int gap, r;
    logic [127:0] round_out;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    state_hi <= st[127:64];
    state_lo <= st[63:0];
    key_hi <= rk[127:64];
    key_lo <= rk[63:0];
    round_out = known ? want : aes_round(m, st, rk);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rounds.push_back(round_out);
  endtask

  initial begin
    int n, sel, j;
    logic [MODE_W-1:0] m;
    logic [127:0] st, rk;
    byte_t pick;
    build_sbox();
    @(posedge clk);
    while (rst) @(posedge clk);
    for (n = 0; n < N_DIRECTED; n++)
      send_word(DIRECTED[n].m, DIRECTED[n].st, DIRECTED[n].rk,
                DIRECTED[n].known, DIRECTED[n].want);
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 4) m = MODE_FULL;
      else if (sel < 7) m = MODE_FINAL;
      else if (sel < 9) m = MODE_ADD_KEY;
      else m = MODE_SPARE;
      st = {$urandom, $urandom, $urandom, $urandom};
      rk = {$urandom, $urandom, $urandom, $urandom};
      // corner bytes now and then
      if ($urandom_range(0, 7) == 0) begin
        for (j = 0; j < 16; j++) begin
          case ($urandom_range(0, 3))
            0: pick = 8'h00;
            1: pick = 8'hff;
            2: pick = 8'h01;
            default: pick = 8'h80;
          endcase
          st[8*j +: 8] = pick;
        end
      end
      send_word(m, st, rk, 1'b0, 128'h0);
    end
    in_valid <= 1'b0;
    while (expected_rounds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back the pipe up
  initial begin
    int len, r;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_stall <= 1'b1;
        len = PRESSURE_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 92) begin
          out_stall <= 1'b0;
          len = $urandom_range(15, 50);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(8, 30);
        end
      end
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_rounds.size() == 0) begin
        report_mismatch("unexpected word", result_hi, 64'h0);
      end else begin
        want = expected_rounds.pop_front();
        if (result_hi !== want[127:64]) report_mismatch("result_hi", result_hi, want[127:64]);
        if (result_lo !== want[63:0]) report_mismatch("result_lo", result_lo, want[63:0]);
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/aesr_pkg.sv
rtl/aes_encrypt_round_unit.sv
verif/tb_top.sv
